@@ rtl/tcba_pkg.sv @@
// ============================================================================
// Task CPU binding allocator package
// Shared constants, register indexes, mode codes, types and helper functions.
// ============================================================================
`default_nettype none

package tcba_pkg;

    localparam int MAX_CPUS = 64;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BIND_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_THREAD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AVAILABLE_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_CPUS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORES_PER_SOCK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOCKET_TOTAL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THREADS_PER_CORE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THREADS_WANTED = 3'd7;

    localparam logic [1:0] MODE_ALL    = 2'd0;
    localparam logic [1:0] MODE_RANK   = 2'd1;
    localparam logic [1:0] MODE_SOCKET = 2'd2;

    typedef struct packed {
        logic [1:0]  bind_mode;
        logic        one_thread_per_core;
        logic [63:0] available_mask;
        logic [6:0]  node_cpus;
        logic [6:0]  socket_cores;
        logic [6:0]  socket_total;
        logic [3:0]  threads_per_core;
        logic [6:0]  threads_wanted;
    } t_cfg;

    typedef struct packed {
        logic [63:0] cpu_set;
        logic        fell_back_all;
        logic        bits_dropped;
    } t_result;

    function automatic logic [63:0] all_bits();
        if (MAX_CPUS >= 64) begin
            return '1;
        end
        return (64'(1) << MAX_CPUS) - 64'(1);
    endfunction

    function automatic logic [6:0] at_least_one(input logic [6:0] v);
        return (v == 7'd0) ? 7'd1 : v;
    endfunction

    function automatic logic [3:0] thread_limit(input logic [3:0] tpc);
        logic [3:0] h;
        h = (tpc == 4'd0) ? 4'd1 : tpc;
        return (h > 4'd8) ? 4'd8 : h;
    endfunction

    // Fallback set: one thread of every core of the node, or every thread.
    function automatic logic [63:0] pin_mask(input logic otpc, input logic [6:0] node);
        logic [63:0] low;
        low = (node >= 7'd64) ? '1 : ((64'(1) << node[5:0]) - 64'(1));
        return otpc ? (low & all_bits()) : all_bits();
    endfunction

    function automatic logic pin_drop(input logic otpc, input logic [6:0] node);
        return otpc && (node > 7'(MAX_CPUS));
    endfunction

endpackage

`default_nettype wire

@@ rtl/tcba_req_if.sv @@
// ============================================================================
// Request channel
// Valid/ready channel that carries one binding request per transaction.
// ============================================================================
`default_nettype none

interface tcba_req_if;
    logic valid;
    logic ready;
    logic start_over;

    modport source (output valid, output start_over, input ready);
    modport sink   (input valid, input start_over, output ready);
endinterface

`default_nettype wire

@@ rtl/tcba_res_if.sv @@
// ============================================================================
// Result channel
// Valid/ready channel that carries one CPU set per transaction.
// ============================================================================
`default_nettype none

interface tcba_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] cpu_set;
    logic        fell_back_all;
    logic        bits_dropped;

    modport source (output valid, output cpu_set, output fell_back_all,
                    output bits_dropped, input ready);
    modport sink   (input valid, input cpu_set, input fell_back_all,
                    input bits_dropped, output ready);
endinterface

`default_nettype wire

@@ rtl/task_cpu_binding_allocator.sv @@
// ============================================================================
// Task CPU binding allocator
// Picks the CPU set for the next task on a node in all, rank or socket mode.
// ============================================================================
// All mode and socket overflow go from idle straight to the output state.
// Rank mode walks one core per cycle, pass after pass over the node's cores.
// Socket mode walks the cores too and stops on each chosen core to add its threads.
// One request is in work at a time; the next is taken while a result waits.
// Synchronous reset: cursor to none, thread level 0, registers to defaults.
`default_nettype none

module task_cpu_binding_allocator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tcba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [63:0]                       i_cfg_data,
    tcba_req_if.sink                               i_req,
    tcba_res_if.source                             o_res
);

    tcba_pkg::t_cfg    r_cfg;
    tcba_pkg::t_result res;
    logic              idle;
    logic              res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bind_mode           <= tcba_pkg::MODE_RANK;
            r_cfg.one_thread_per_core <= 1'b0;
            r_cfg.available_mask      <= '0;
            r_cfg.node_cpus           <= 7'd1;
            r_cfg.socket_cores        <= 7'd1;
            r_cfg.socket_total        <= 7'd1;
            r_cfg.threads_per_core    <= 4'd1;
            r_cfg.threads_wanted      <= 7'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcba_pkg::REG_BIND_MODE:        r_cfg.bind_mode <= i_cfg_data[1:0];
                tcba_pkg::REG_ONE_THREAD:       r_cfg.one_thread_per_core <= i_cfg_data[0];
                tcba_pkg::REG_AVAILABLE_MASK:   r_cfg.available_mask <= i_cfg_data;
                tcba_pkg::REG_NODE_CPUS:        r_cfg.node_cpus <= i_cfg_data[6:0];
                tcba_pkg::REG_CORES_PER_SOCK:   r_cfg.socket_cores <= i_cfg_data[6:0];
                tcba_pkg::REG_SOCKET_TOTAL:     r_cfg.socket_total <= i_cfg_data[6:0];
                tcba_pkg::REG_THREADS_PER_CORE: r_cfg.threads_per_core <= i_cfg_data[3:0];
                tcba_pkg::REG_THREADS_WANTED:   r_cfg.threads_wanted <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    tcba_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_start      (i_req.valid && idle),
        .i_start_over (i_req.start_over),
        .o_idle       (idle),
        .o_res_valid  (res_valid),
        .i_res_ready  (o_res.ready),
        .o_res        (res)
    );

    assign i_req.ready         = idle;
    assign o_res.valid         = res_valid;
    assign o_res.cpu_set       = res.cpu_set;
    assign o_res.fell_back_all = res.fell_back_all;
    assign o_res.bits_dropped  = res.bits_dropped;

endmodule

`default_nettype wire

@@ rtl/tcba_bit_unit.sv @@
// ============================================================================
// Thread bit unit
// Maps a core and a thread level to a hardware thread bit and flags indexes
// that fall outside the CPU set.
// ============================================================================
`default_nettype none

module tcba_bit_unit (
    input  wire logic [6:0]  i_core,
    input  wire logic [2:0]  i_mult,
    input  wire logic [6:0]  i_node,
    output logic      [63:0] o_bit,
    output logic             o_drop
);

    logic [9:0] prod;
    logic [9:0] idx;
    logic       in_range;

    assign prod     = 10'(i_mult) * 10'(i_node);
    assign idx      = prod + 10'(i_core);
    assign in_range = idx < 10'(tcba_pkg::MAX_CPUS);
    assign o_bit    = in_range ? (64'(1) << idx[5:0]) : '0;
    assign o_drop   = !in_range;

endmodule

`default_nettype wire

@@ rtl/tcba_seq.sv @@
// ============================================================================
// Binding sequencer
// Walks the cores one per cycle in rank or socket mode (socket mode waits while it adds a chosen core's
// threads), drives the shared thread bit unit and holds the cursor, thread level and result register.
// ============================================================================
`default_nettype none

module tcba_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tcba_pkg::t_cfg   i_cfg,
    input  wire logic             i_start,
    input  wire logic             i_start_over,
    output logic                  o_idle,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output tcba_pkg::t_result     o_res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RANK = 3'd1;
    localparam logic [2:0] ST_SOCK = 3'd2;
    localparam logic [2:0] ST_THR  = 3'd3;
    localparam logic [2:0] ST_SFIN = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic              r_cur_vld, n_cur_vld;
    logic [6:0]        r_cur, n_cur;
    logic [2:0]        r_level, n_level;
    logic [6:0]        r_c, n_c;
    logic [6:0]        r_found, n_found;
    logic [63:0]       r_acc, n_acc;
    logic              r_drop, n_drop;
    logic              r_fell, n_fell;
    logic [6:0]        r_pos, n_pos;
    logic [6:0]        r_sock, n_sock;
    logic              r_us_vld, n_us_vld;
    logic [6:0]        r_us, n_us;
    logic [7:0]        r_cap, n_cap;
    logic [2:0]        r_t, n_t;
    logic              r_ovld, n_ovld;
    tcba_pkg::t_result r_ores, n_ores;

    logic [6:0]  want;
    logic [6:0]  cps;
    logic [3:0]  hw;
    logic        core_free;
    logic [2:0]  mult;
    logic [63:0] u_bit;
    logic        u_drop;
    logic [2:0]  lvl_next;
    logic        pos_wrap;
    logic [6:0]  pos_next;
    logic [6:0]  sock_next;
    logic        cap_hit;
    logic [13:0] sock_cap;
    logic        wrap;
    logic        found_last;
    logic        new_sock;
    logic        adv;

    assign want      = tcba_pkg::at_least_one(i_cfg.threads_wanted);
    assign cps       = tcba_pkg::at_least_one(i_cfg.socket_cores);
    assign hw        = tcba_pkg::thread_limit(i_cfg.threads_per_core);
    assign core_free = (r_c < 7'd64) && i_cfg.available_mask[r_c[5:0]];
    assign mult      = (r_state == ST_THR) ? r_t : ((r_state == ST_RANK) ? r_level : 3'd0);
    assign lvl_next  = ((4'(r_level) + 4'd1) >= hw) ? 3'd0 : (r_level + 3'd1);
    assign pos_wrap  = (8'(r_pos) + 8'd1) == 8'(cps);
    assign pos_next  = pos_wrap ? 7'd0 : (r_pos + 7'd1);
    assign sock_next = pos_wrap ? (r_sock + 7'd1) : r_sock;
    assign cap_hit   = r_cap >= 8'(want);
    assign sock_cap  = 14'(cps) * 14'(i_cfg.socket_total);
    assign wrap      = r_cur_vld && ((8'(r_cur) + 8'd1) >= 8'(i_cfg.node_cpus));
    assign found_last = (8'(r_found) + 8'd1) == 8'(want);
    assign new_sock  = r_us_vld && (r_sock != r_us);

    tcba_bit_unit u_bit_unit (
        .i_core (r_c),
        .i_mult (mult),
        .i_node (i_cfg.node_cpus),
        .o_bit  (u_bit),
        .o_drop (u_drop)
    );

    always_comb begin
        n_state   = r_state;
        n_cur_vld = r_cur_vld;
        n_cur     = r_cur;
        n_level   = r_level;
        n_c       = r_c;
        n_found   = r_found;
        n_acc     = r_acc;
        n_drop    = r_drop;
        n_fell    = r_fell;
        n_pos     = r_pos;
        n_sock    = r_sock;
        n_us_vld  = r_us_vld;
        n_us      = r_us;
        n_cap     = r_cap;
        n_t       = r_t;
        n_ovld    = r_ovld && !i_res_ready;
        n_ores    = r_ores;
        adv       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_acc   = '0;
                    n_drop  = 1'b0;
                    n_fell  = 1'b0;
                    n_c     = '0;
                    n_found = '0;
                    if (i_start_over) begin
                        n_cur_vld = 1'b0;
                        n_level   = '0;
                    end
                    unique case (i_cfg.bind_mode)
                        tcba_pkg::MODE_ALL: begin
                            n_acc   = tcba_pkg::all_bits();
                            n_state = ST_OUT;
                        end
                        tcba_pkg::MODE_SOCKET: begin
                            if (14'(want) > sock_cap) begin
                                n_acc   = tcba_pkg::pin_mask(i_cfg.one_thread_per_core,
                                                             i_cfg.node_cpus);
                                n_drop  = tcba_pkg::pin_drop(i_cfg.one_thread_per_core,
                                                             i_cfg.node_cpus);
                                n_fell  = 1'b1;
                                n_state = ST_OUT;
                            end else begin
                                n_pos    = '0;
                                n_sock   = '0;
                                n_us_vld = 1'b0;
                                n_cap    = 8'(cps);
                                n_state  = ST_SOCK;
                            end
                        end
                        default: begin
                            if (i_cfg.one_thread_per_core) begin
                                n_level = '0;
                            end
                            n_state = ST_RANK;
                        end
                    endcase
                end
            end
            ST_RANK: begin
                if (r_c >= i_cfg.node_cpus) begin
                    if (r_found == 7'd0 && !r_cur_vld) begin
                        n_state = ST_OUT;
                    end else begin
                        n_cur_vld = 1'b0;
                        n_level   = i_cfg.one_thread_per_core ? 3'd0 : lvl_next;
                        n_c       = '0;
                    end
                end else begin
                    if ((!r_cur_vld || r_cur < r_c) && core_free) begin
                        n_acc     = r_acc | u_bit;
                        n_drop    = r_drop | u_drop;
                        n_cur     = r_c;
                        n_cur_vld = 1'b1;
                        n_found   = r_found + 7'd1;
                        if (found_last) begin
                            n_state = ST_OUT;
                        end
                    end
                    n_c = r_c + 7'd1;
                end
            end
            ST_SOCK: begin
                if (r_c >= i_cfg.node_cpus) begin
                    n_state = ST_SFIN;
                end else if ((r_cur_vld && r_c <= r_cur) || !core_free) begin
                    adv = 1'b1;
                end else if (new_sock && cap_hit) begin
                    n_state = ST_SFIN;
                end else begin
                    if (new_sock) begin
                        n_cap = r_cap + 8'(cps);
                    end
                    n_acc     = r_acc | u_bit;
                    n_drop    = r_drop | u_drop;
                    n_us_vld  = 1'b1;
                    n_us      = r_sock;
                    n_cur     = r_c;
                    n_cur_vld = 1'b1;
                    if (!i_cfg.one_thread_per_core && hw > 4'd1) begin
                        n_t     = 3'd1;
                        n_state = ST_THR;
                    end else begin
                        adv = 1'b1;
                    end
                end
            end
            ST_THR: begin
                n_acc  = r_acc | u_bit;
                n_drop = r_drop | u_drop;
                if ((4'(r_t) + 4'd1) >= hw) begin
                    adv     = 1'b1;
                    n_state = ST_SOCK;
                end else begin
                    n_t = r_t + 3'd1;
                end
            end
            ST_SFIN: begin
                if (!r_us_vld) begin
                    n_acc  = r_acc | tcba_pkg::pin_mask(i_cfg.one_thread_per_core,
                                                        i_cfg.node_cpus);
                    n_drop = r_drop | tcba_pkg::pin_drop(i_cfg.one_thread_per_core,
                                                         i_cfg.node_cpus);
                    n_fell = 1'b1;
                end
                if (wrap) begin
                    n_cur_vld = 1'b0;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovld || i_res_ready) begin
                    n_ovld                = 1'b1;
                    n_ores.cpu_set        = r_acc & tcba_pkg::all_bits();
                    n_ores.fell_back_all  = r_fell;
                    n_ores.bits_dropped   = r_drop;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (adv) begin
            n_c    = r_c + 7'd1;
            n_pos  = pos_next;
            n_sock = sock_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cur_vld <= 1'b0;
            r_level   <= '0;
            r_ovld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur_vld <= n_cur_vld;
            r_level   <= n_level;
            r_ovld    <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_c      <= n_c;
        r_found  <= n_found;
        r_acc    <= n_acc;
        r_drop   <= n_drop;
        r_fell   <= n_fell;
        r_pos    <= n_pos;
        r_sock   <= n_sock;
        r_us_vld <= n_us_vld;
        r_us     <= n_us;
        r_cap    <= n_cap;
        r_t      <= n_t;
        r_ores   <= n_ores;
    end

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = r_ovld;
    assign o_res       = r_ores;

endmodule

`default_nettype wire

@@ test/tcba_binding_checker.sv @@
// ============================================================================
// Binding result checker
// Watches the register writes and both channels of the allocator, keeps its
// own copy of the cursor, the thread level and the registers, predicts the
// CPU set of every accepted request and compares it with each result.
// ============================================================================

module tcba_binding_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    tcba_req_if                            i_req,
    tcba_res_if                            i_res,
    output int                             o_fails,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcba_pkg::*;

    t_cfg        regs;
    int          cursor_core;
    int          thread_lvl;
    logic [63:0] pick_set;
    logic        pick_drop;
    t_result     expected_sets[$];
    int          mismatches = 0;
    int          pending_count = 0;

    assign o_fails   = mismatches;
    assign o_pending = pending_count;

    function automatic int nonzero(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic int usable_threads();
        int h;
        h = nonzero(int'(regs.threads_per_core));
        return (h > 8) ? 8 : h;
    endfunction

    function automatic bit core_open(input int c);
        if (c >= 64) begin
            return 1'b0;
        end
        return regs.available_mask[c];
    endfunction

    function automatic void claim_thread(input int idx);
        if (idx < MAX_CPUS) begin
            pick_set[idx] = 1'b1;
        end else begin
            pick_drop = 1'b1;
        end
    endfunction

    function automatic void pin_every_cpu();
        if (regs.one_thread_per_core) begin
            for (int c = 0; c < int'(regs.node_cpus); c++) begin
                claim_thread(c);
            end
        end else begin
            pick_set = '1;
        end
    endfunction

    function automatic void walk_rank();
        int hw;
        int want;
        int found;
        int node;
        bit done;
        hw    = usable_threads();
        want  = nonzero(int'(regs.threads_wanted));
        node  = int'(regs.node_cpus);
        found = 0;
        done  = 1'b0;
        if (regs.one_thread_per_core) begin
            thread_lvl = 0;
            hw = 1;
        end
        while (!done) begin
            for (int c = 0; c < node && !done; c++) begin
                if ((cursor_core < 0 || cursor_core < c) && core_open(c)) begin
                    claim_thread(c + thread_lvl * node);
                    cursor_core = c;
                    found++;
                    if (found == want) begin
                        done = 1'b1;
                    end
                end
            end
            if (!done) begin
                if (found == 0 && cursor_core < 0) begin
                    done = 1'b1;
                end else begin
                    cursor_core = -1;
                    thread_lvl = (thread_lvl + 1 >= hw) ? 0 : thread_lvl + 1;
                end
            end
        end
    endfunction

    function automatic bit walk_socket();
        int cps;
        int want;
        int hw;
        int node;
        int needed;
        int used_count;
        int used_sock;
        int sock;
        bit stop;
        bit fell;
        cps        = nonzero(int'(regs.socket_cores));
        want       = nonzero(int'(regs.threads_wanted));
        hw         = usable_threads();
        node       = int'(regs.node_cpus);
        used_count = 1;
        used_sock  = -1;
        stop       = 1'b0;
        fell       = 1'b0;
        if (want > cps * int'(regs.socket_total)) begin
            pin_every_cpu();
            return 1'b1;
        end
        needed = (want + cps - 1) / cps;
        for (int c = 0; c < node && !stop; c++) begin
            if (!((cursor_core >= 0 && c <= cursor_core) || !core_open(c))) begin
                sock = c / cps;
                if (used_sock >= 0 && sock != used_sock && needed == used_count) begin
                    stop = 1'b1;
                end else begin
                    if (used_sock >= 0 && sock != used_sock) begin
                        used_count++;
                    end
                    if (regs.one_thread_per_core) begin
                        claim_thread(c);
                    end else begin
                        for (int t = 0; t < hw; t++) begin
                            claim_thread(c + t * node);
                        end
                    end
                    used_sock = sock;
                    cursor_core = c;
                end
            end
        end
        if (used_sock < 0) begin
            pin_every_cpu();
            fell = 1'b1;
        end
        if (cursor_core + 1 >= node) begin
            cursor_core = -1;
        end
        return fell;
    endfunction

    function automatic t_result predict_binding(input logic start_over);
        t_result r;
        bit      fell;
        fell = 1'b0;
        if (start_over) begin
            cursor_core = -1;
            thread_lvl = 0;
        end
        pick_set = '0;
        pick_drop = 1'b0;
        case (regs.bind_mode)
            MODE_ALL: begin
                pick_set = '1;
            end
            MODE_SOCKET: begin
                fell = walk_socket();
            end
            default: begin
                walk_rank();
            end
        endcase
        r.cpu_set = pick_set;
        r.fell_back_all = fell;
        r.bits_dropped = pick_drop;
        return r;
    endfunction

    function automatic void compare_field(input string label, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result oldest;
        if (!i_rst_n) begin
            regs.bind_mode           = MODE_RANK;
            regs.one_thread_per_core = 1'b0;
            regs.available_mask      = '0;
            regs.node_cpus           = 7'd1;
            regs.socket_cores        = 7'd1;
            regs.socket_total        = 7'd1;
            regs.threads_per_core    = 4'd1;
            regs.threads_wanted      = 7'd1;
            cursor_core              = -1;
            thread_lvl               = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BIND_MODE:        regs.bind_mode           = i_cfg_data[1:0];
                    REG_ONE_THREAD:       regs.one_thread_per_core = i_cfg_data[0];
                    REG_AVAILABLE_MASK:   regs.available_mask      = i_cfg_data;
                    REG_NODE_CPUS:        regs.node_cpus           = i_cfg_data[6:0];
                    REG_CORES_PER_SOCK:   regs.socket_cores        = i_cfg_data[6:0];
                    REG_SOCKET_TOTAL:     regs.socket_total        = i_cfg_data[6:0];
                    REG_THREADS_PER_CORE: regs.threads_per_core    = i_cfg_data[3:0];
                    REG_THREADS_WANTED:   regs.threads_wanted      = i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_sets.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_res.cpu_set);
                    mismatches++;
                end else begin
                    oldest = expected_sets.pop_front();
                    pending_count--;
                    compare_field("cpu_set", oldest.cpu_set, i_res.cpu_set);
                    compare_field("fell_back_all", 64'(oldest.fell_back_all),
                                  64'(i_res.fell_back_all));
                    compare_field("bits_dropped", 64'(oldest.bits_dropped),
                                  64'(i_res.bits_dropped));
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_sets.push_back(predict_binding(i_req.start_over));
                pending_count++;
            end
        end
    end

endmodule

@@ test/task_cpu_binding_allocator_test.sv @@
// ============================================================================
// Task CPU binding allocator testbench
// Drives binding requests through a range of register settings, first a few
// hand-picked cases and then random ones, with random gaps on both channels;
// a separate checker predicts and compares every CPU set.
// ============================================================================

module task_cpu_binding_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcba_pkg::*;

    localparam logic [1:0] MODE_RANK_ALT = 2'd3;
    localparam int RANDOM_ITEMS = 1550;
    localparam int CALM_AFTER   = 1400;
    localparam int LONG_HOLD    = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [63:0]          cfg_data = '0;

    tcba_req_if req_ch ();
    tcba_res_if res_ch ();

    int check_fails;
    int check_pending;
    int sent_count = 0;
    int results_seen = 0;
    int hold_token = 0;
    bit idling = 1'b1;

    task_cpu_binding_allocator DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    tcba_binding_checker binding_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .i_res      (res_ch),
        .o_fails    (check_fails),
        .o_pending  (check_pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        int hold_taken;
        int hold_left;
        int gap_left;
        hold_taken = 0;
        hold_left  = 0;
        gap_left   = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready) begin
                results_seen <= results_seen + 1;
            end
            if (!rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_token != hold_taken) begin
                hold_taken = hold_token;
                hold_left = LONG_HOLD - 1;
                res_ch.ready <= 1'b0;
            end else if (gap_left > 0) begin
                res_ch.ready <= 1'b0;
                gap_left--;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                gap_left = $urandom_range(0, 17);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic apply_cfg(input t_cfg c);
        write_reg(REG_BIND_MODE, 64'(c.bind_mode));
        write_reg(REG_ONE_THREAD, 64'(c.one_thread_per_core));
        write_reg(REG_AVAILABLE_MASK, c.available_mask);
        write_reg(REG_NODE_CPUS, 64'(c.node_cpus));
        write_reg(REG_CORES_PER_SOCK, 64'(c.socket_cores));
        write_reg(REG_SOCKET_TOTAL, 64'(c.socket_total));
        write_reg(REG_THREADS_PER_CORE, 64'(c.threads_per_core));
        write_reg(REG_THREADS_WANTED, 64'(c.threads_wanted));
    endtask

    task automatic wait_drained();
        while (results_seen != sent_count) @(posedge clk);
    endtask

    task automatic send_req(input logic so);
        int gap;
        if (idling && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.start_over <= so;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_count++;
    endtask

    // The request channel is lowered once a group ends; time always advances
    // before the next group raises it again.
    task automatic run_group(input t_cfg c, input int count, input logic [63:0] so_bits,
                             input int pause_at);
        wait_drained();
        apply_cfg(c);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) begin
                req_ch.valid <= 1'b0;
                wait_drained();
            end
            send_req(so_bits[i]);
        end
        req_ch.valid <= 1'b0;
    endtask

    function automatic t_cfg make_cfg(input logic [1:0] mode, input logic otpc,
                                      input logic [63:0] mask, input int node,
                                      input int cps, input int sockets, input int tpc,
                                      input int tw);
        t_cfg c;
        c.bind_mode           = mode;
        c.one_thread_per_core = otpc;
        c.available_mask      = mask;
        c.node_cpus           = 7'(node);
        c.socket_cores        = 7'(cps);
        c.socket_total        = 7'(sockets);
        c.threads_per_core    = 4'(tpc);
        c.threads_wanted      = 7'(tw);
        return c;
    endfunction

    function automatic t_cfg random_setting();
        t_cfg c;
        int   pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            c.bind_mode = MODE_ALL;
        end else if (pick == 1) begin
            c.bind_mode = MODE_RANK_ALT;
        end else if (pick < 6) begin
            c.bind_mode = MODE_RANK;
        end else begin
            c.bind_mode = MODE_SOCKET;
        end
        c.one_thread_per_core = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 6))
            0: c.available_mask = {$urandom, $urandom};
            1: c.available_mask = {$urandom, $urandom} & {$urandom, $urandom};
            2: c.available_mask = {$urandom, $urandom} | {$urandom, $urandom};
            3: c.available_mask = '1;
            4: c.available_mask = 64'd1 << $urandom_range(0, 63);
            5: c.available_mask = {$urandom, $urandom} & {$urandom, $urandom}
                                  & {$urandom, $urandom};
            default: c.available_mask = '0;
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
            c.node_cpus = 7'($urandom_range(1, 16));
        end else if (pick < 17) begin
            c.node_cpus = 7'($urandom_range(17, 48));
        end else begin
            c.node_cpus = 7'($urandom_range(49, 64));
        end
        c.socket_cores = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(1, 64))
                                                     : 7'($urandom_range(1, 16));
        c.socket_total = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(1, 64))
                                                     : 7'($urandom_range(1, 8));
        c.threads_per_core = 4'($urandom_range(1, 8));
        c.threads_wanted = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(9, 64))
                                                       : 7'($urandom_range(1, 8));
        return c;
    endfunction

    initial begin
        t_cfg        setting;
        int          n;
        int          phase;
        int          base;
        bit          idle_next;
        logic [63:0] so_bits;
        req_ch.valid      <= 1'b0;
        req_ch.start_over <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still at their reset values: rank mode with no core free.
        send_req(1'b0);
        req_ch.valid <= 1'b0;

        run_group(make_cfg(MODE_ALL, 1'b1, 64'h0123_4567_89AB_CDEF, 8, 4, 2, 2, 3),
                  1, 64'h0, -1);
        run_group(make_cfg(MODE_RANK_ALT, 1'b0, 64'hA5, 8, 4, 2, 2, 3), 4, 64'h8, -1);
        run_group(make_cfg(MODE_RANK, 1'b1, 64'hF0F0, 16, 4, 4, 4, 5), 2, 64'h0, -1);
        run_group(make_cfg(MODE_SOCKET, 1'b0, 64'h6DB6, 16, 4, 4, 2, 5), 4, 64'h8, -1);
        run_group(make_cfg(MODE_SOCKET, 1'b0, '1, 16, 4, 2, 3, 64), 1, 64'h0, -1);
        run_group(make_cfg(MODE_SOCKET, 1'b1, '1, 100, 4, 2, 3, 64), 1, 64'h0, -1);
        run_group(make_cfg(MODE_SOCKET, 1'b0, 64'h0, 16, 4, 4, 2, 2), 1, 64'h0, -1);
        run_group(make_cfg(MODE_RANK, 1'b0, 64'h0F, 8, 0, 1, 0, 0), 2, 64'h1, -1);
        run_group(make_cfg(MODE_SOCKET, 1'b0, 64'h0F, 8, 0, 1, 0, 0), 1, 64'h0, -1);
        run_group(make_cfg(MODE_RANK, 1'b0, 64'h3, 8, 1, 1, 15, 4), 3, 64'h1, -1);
        run_group(make_cfg(MODE_RANK, 1'b0, '1, 127, 8, 16, 8, 64), 2, 64'h0, -1);
        run_group(make_cfg(MODE_SOCKET, 1'b0, '1, 64, 64, 1, 8, 64), 1, 64'h1, -1);

        base = sent_count;
        phase = 0;
        while (sent_count - base < RANDOM_ITEMS) begin
            setting = random_setting();
            n = (setting.threads_wanted > 7'd8) ? $urandom_range(4, 10)
                                                : $urandom_range(12, 40);
            so_bits = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            wait_drained();
            idle_next = (sent_count - base < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            if (phase == 6) begin
                idle_next = 1'b0;
                setting.threads_wanted = 7'($urandom_range(1, 8));
                n = 40;
                hold_token <= hold_token + 1;
            end
            idling <= idle_next;
            run_group(setting, n, so_bits, (phase == 12) ? n / 2 : -1);
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (check_fails == 0 && check_pending == 0) begin
            $display("task_cpu_binding_allocator_test: done, clean");
        end else begin
            $display("task_cpu_binding_allocator_test: done, errors");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("task_cpu_binding_allocator_test: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tcba_pkg.sv
rtl/tcba_req_if.sv
rtl/tcba_res_if.sv
rtl/tcba_bit_unit.sv
rtl/tcba_seq.sv
rtl/task_cpu_binding_allocator.sv
test/tcba_binding_checker.sv
test/task_cpu_binding_allocator_test.sv
